>>> rtl/rpw_pkg.sv
`default_nettype none
package rpw_pkg;

    // Geometry of the table and of the frame store.
    localparam int OFFSET_BITS = 4;
    localparam int LEVELS      = 3;
    localparam int FRAME_COUNT = 32;
    localparam int WORD_BITS   = 32;

    localparam int PAGE_WORDS = 1 << OFFSET_BITS;
    localparam int FRAME_W    = $clog2(FRAME_COUNT);
    localparam int RAM_AW     = FRAME_W + OFFSET_BITS;
    localparam int RAM_DEPTH  = FRAME_COUNT * PAGE_WORDS;
    localparam int VA_BITS    = OFFSET_BITS * (LEVELS + 1);
    localparam int PAGE_BITS  = OFFSET_BITS * LEVELS;
    localparam int PAGE_COUNT = 1 << PAGE_BITS;
    localparam int SWAP_AW    = VA_BITS;
    localparam int SWAP_DEPTH = 1 << SWAP_AW;
    localparam int IDX_W      = OFFSET_BITS + 1;
    localparam int LVL_W      = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int CLR_W      = (PAGE_BITS > RAM_AW) ? PAGE_BITS : RAM_AW;

    // Operation codes of an input item.
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Request bundles from the sequencer to the three memories.
    typedef struct packed {
        logic                 we;
        logic [RAM_AW-1:0]    waddr;
        logic [WORD_BITS-1:0] wdata;
        logic [RAM_AW-1:0]    raddr;
    } frame_req_t;

    typedef struct packed {
        logic                 we;
        logic [SWAP_AW-1:0]   waddr;
        logic [WORD_BITS-1:0] wdata;
        logic [SWAP_AW-1:0]   raddr;
    } swap_req_t;

    typedef struct packed {
        logic                 we;
        logic [PAGE_BITS-1:0] waddr;
        logic                 wdata;
        logic [PAGE_BITS-1:0] raddr;
    } saved_req_t;

endpackage
`default_nettype wire

>>> rtl/rpw_ram.sv
`default_nettype none
module rpw_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

>>> rtl/rpw_ctrl.sv
`default_nettype none
module rpw_ctrl
    import rpw_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic                 s_op,
    input  wire logic [31:0]          s_virtual_address,
    input  wire logic signed [31:0]   s_write_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic signed [31:0]        m_read_data,
    output logic                      m_ok,
    output frame_req_t                frame_req,
    input  wire logic [WORD_BITS-1:0] frame_rdata,
    output swap_req_t                 swap_req,
    input  wire logic [WORD_BITS-1:0] swap_rdata,
    output saved_req_t                saved_req,
    input  wire logic                 saved_rdata
);

    typedef enum logic [18:0] {
        ST_CLR   = 19'h00001,
        ST_IDLE  = 19'h00002,
        ST_WALK  = 19'h00004,
        ST_WDAT  = 19'h00008,
        ST_ZRD   = 19'h00010,
        ST_CRD   = 19'h00020,
        ST_CDAT  = 19'h00040,
        ST_DEC   = 19'h00080,
        ST_EVRD  = 19'h00100,
        ST_EVCP  = 19'h00200,
        ST_EVEND = 19'h00400,
        ST_NEWF  = 19'h00800,
        ST_TCLR  = 19'h01000,
        ST_SVRD  = 19'h02000,
        ST_SVCP  = 19'h04000,
        ST_LINK  = 19'h08000,
        ST_ACC   = 19'h10000,
        ST_ADAT  = 19'h20000,
        ST_FIN   = 19'h40000
    } state_t;

    state_t                   state_reg, state_next;
    logic                     op_reg, op_next;
    logic [31:0]              va_reg, va_next;
    logic signed [31:0]       wdata_reg, wdata_next;
    logic [LVL_W-1:0]         level_reg, level_next;
    logic [FRAME_W-1:0]       parent_reg, parent_next;
    logic [FRAME_W-1:0]       last_reg, last_next;
    logic [RAM_AW-1:0]        ea_reg, ea_next;
    logic [FRAME_W-1:0]       sf_reg [LEVELS];
    logic [FRAME_W-1:0]       sf_next [LEVELS];
    logic [IDX_W-1:0]         si_reg [LEVELS];
    logic [IDX_W-1:0]         si_next [LEVELS];
    logic [LVL_W-1:0]         sd_reg, sd_next;
    logic [IDX_W-1:0]         k_reg, k_next;
    logic [OFFSET_BITS-1:0]   kd_reg, kd_next;
    logic                     rv_reg, rv_next;
    logic                     allz_reg, allz_next;
    logic [FRAME_W-1:0]       highest_reg, highest_next;
    logic [FRAME_W-1:0]       free_reg, free_next;
    logic [FRAME_W-1:0]       nf_reg, nf_next;
    logic [RAM_AW-1:0]        vaddr_reg, vaddr_next;
    logic [PAGE_BITS-1:0]     vdist_reg, vdist_next;
    logic [PAGE_BITS-1:0]     vpage_reg, vpage_next;
    logic signed [31:0]       res_reg, res_next;
    logic                     okr_reg, okr_next;
    logic                     mvalid_reg, mvalid_next;
    logic signed [31:0]       mdata_reg, mdata_next;
    logic                     mok_reg, mok_next;
    logic [CLR_W-1:0]         clr_reg, clr_next;

    logic [OFFSET_BITS-1:0]   off;
    logic [PAGE_BITS-1:0]     want_page;
    logic [FRAME_W-1:0]       cur_frame;
    logic [IDX_W-1:0]         cur_idx;
    logic [LVL_W-1:0]         sd_m1;
    logic [LVL_W-1:0]         sd_p1;
    logic [PAGE_BITS-1:0]     leaf_page;
    logic [PAGE_BITS-1:0]     diff;
    logic [PAGE_BITS:0]       alt;
    logic [PAGE_BITS-1:0]     leaf_dist;
    logic                     allz_f;
    logic                     out_of_range;

    assign s_ready     = (state_reg == ST_IDLE);
    assign m_valid     = mvalid_reg;
    assign m_read_data = mdata_reg;
    assign m_ok        = mok_reg;

    // Table index of the current walk level.
    always_comb begin
        off = '0;
        for (int l = 0; l < LEVELS; l++) begin
            if (level_reg == LVL_W'(l)) begin
                off = va_reg[OFFSET_BITS*(LEVELS-l) +: OFFSET_BITS];
            end
        end
    end

    assign want_page = va_reg[VA_BITS-1:OFFSET_BITS];
    assign cur_frame = sf_reg[sd_reg];
    assign cur_idx   = si_reg[sd_reg];
    assign sd_m1     = sd_reg - 1'b1;
    assign sd_p1     = sd_reg + 1'b1;
    assign out_of_range = (s_virtual_address >> VA_BITS) != 32'd0;

    // Page number of a leaf is the chain of indexes on the scan stack.
    always_comb begin
        leaf_page = '0;
        for (int d = 0; d < LEVELS; d++) begin
            leaf_page = (leaf_page << OFFSET_BITS)
                      | PAGE_BITS'(si_reg[d][OFFSET_BITS-1:0]);
        end
    end

    // Cyclic distance between the leaf page and the wanted page.
    always_comb begin
        diff = (leaf_page > want_page) ? (leaf_page - want_page) : (want_page - leaf_page);
        alt  = (PAGE_BITS+1)'(PAGE_COUNT) - {1'b0, diff};
        leaf_dist = (alt < {1'b0, diff}) ? alt[PAGE_BITS-1:0] : diff;
    end

    assign allz_f = allz_reg & ~(rv_reg & (frame_rdata != '0));

    // Sequencer.
    always_comb begin
        state_next   = state_reg;
        op_next      = op_reg;
        va_next      = va_reg;
        wdata_next   = wdata_reg;
        level_next   = level_reg;
        parent_next  = parent_reg;
        last_next    = last_reg;
        ea_next      = ea_reg;
        sf_next      = sf_reg;
        si_next      = si_reg;
        sd_next      = sd_reg;
        k_next       = k_reg;
        kd_next      = kd_reg;
        rv_next      = rv_reg;
        allz_next    = allz_reg;
        highest_next = highest_reg;
        free_next    = free_reg;
        nf_next      = nf_reg;
        vaddr_next   = vaddr_reg;
        vdist_next   = vdist_reg;
        vpage_next   = vpage_reg;
        res_next     = res_reg;
        okr_next     = okr_reg;
        mvalid_next  = mvalid_reg;
        mdata_next   = mdata_reg;
        mok_next     = mok_reg;
        clr_next     = clr_reg;
        frame_req    = '0;
        swap_req     = '0;
        saved_req    = '0;

        if (mvalid_reg && m_ready) begin
            mvalid_next = 1'b0;
        end

        case (state_reg)
            ST_CLR: begin
                // Clearing pass over the frame RAM and the saved flags.
                frame_req.we    = 1'b1;
                frame_req.waddr = clr_reg[RAM_AW-1:0];
                saved_req.we    = 1'b1;
                saved_req.waddr = clr_reg[PAGE_BITS-1:0];
                clr_next        = clr_reg + 1'b1;
                if (clr_reg == {CLR_W{1'b1}}) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    op_next     = s_op;
                    va_next     = s_virtual_address;
                    wdata_next  = s_write_data;
                    level_next  = '0;
                    parent_next = '0;
                    last_next   = '0;
                    if (out_of_range) begin
                        res_next   = '0;
                        okr_next   = 1'b0;
                        state_next = ST_FIN;
                    end else begin
                        state_next = ST_WALK;
                    end
                end
            end
            ST_WALK: begin
                frame_req.raddr = {parent_reg, off};
                ea_next         = {parent_reg, off};
                state_next      = ST_WDAT;
            end
            ST_WDAT: begin
                if (frame_rdata == '0) begin
                    // Missing entry: set up a scan of the whole tree.
                    vaddr_next   = '0;
                    vdist_next   = '0;
                    vpage_next   = '0;
                    highest_next = '0;
                    free_next    = '0;
                    sd_next      = '0;
                    sf_next[0]   = '0;
                    k_next       = '0;
                    rv_next      = 1'b0;
                    allz_next    = 1'b1;
                    state_next   = ST_ZRD;
                end else begin
                    parent_next = frame_rdata[FRAME_W-1:0];
                    last_next   = frame_rdata[FRAME_W-1:0];
                    if (level_reg == LVL_W'(LEVELS - 1)) begin
                        state_next = ST_ACC;
                    end else begin
                        level_next = level_reg + 1'b1;
                        state_next = ST_WALK;
                    end
                end
            end
            ST_ZRD: begin
                // Stream the table words and check that all are zero.
                if (rv_reg && frame_rdata != '0) begin
                    allz_next = 1'b0;
                end
                if (k_reg != IDX_W'(PAGE_WORDS)) begin
                    frame_req.raddr = {cur_frame, k_reg[OFFSET_BITS-1:0]};
                    k_next          = k_reg + 1'b1;
                    rv_next         = 1'b1;
                end else begin
                    rv_next    = 1'b0;
                    state_next = ST_CRD;
                    if (allz_f && cur_frame != '0 && cur_frame != last_reg) begin
                        // Empty table: unlink it and keep it as the free frame.
                        free_next       = cur_frame;
                        frame_req.we    = 1'b1;
                        frame_req.waddr = {sf_reg[sd_m1], si_reg[sd_m1][OFFSET_BITS-1:0]};
                        sd_next         = sd_m1;
                        si_next[sd_m1]  = si_reg[sd_m1] + 1'b1;
                    end else begin
                        si_next[sd_reg] = '0;
                    end
                end
            end
            ST_CRD: begin
                if (cur_idx == IDX_W'(PAGE_WORDS)) begin
                    if (sd_reg == '0) begin
                        state_next = ST_DEC;
                    end else begin
                        sd_next        = sd_m1;
                        si_next[sd_m1] = si_reg[sd_m1] + 1'b1;
                    end
                end else begin
                    frame_req.raddr = {cur_frame, cur_idx[OFFSET_BITS-1:0]};
                    state_next      = ST_CDAT;
                end
            end
            ST_CDAT: begin
                if (frame_rdata > WORD_BITS'(highest_reg)) begin
                    highest_next = frame_rdata[FRAME_W-1:0];
                end
                state_next = ST_CRD;
                si_next[sd_reg] = cur_idx + 1'b1;
                if (frame_rdata != '0) begin
                    if (sd_reg == LVL_W'(LEVELS - 1)) begin
                        // Mapped page: candidate for eviction.
                        if (vdist_reg < leaf_dist) begin
                            vaddr_next = {cur_frame, cur_idx[OFFSET_BITS-1:0]};
                            vdist_next = leaf_dist;
                            vpage_next = leaf_page;
                        end
                    end else begin
                        si_next[sd_reg] = cur_idx;
                        sf_next[sd_p1]  = frame_rdata[FRAME_W-1:0];
                        sd_next         = sd_p1;
                        k_next          = '0;
                        rv_next         = 1'b0;
                        allz_next       = 1'b1;
                        state_next      = ST_ZRD;
                    end
                end
            end
            ST_DEC: begin
                if (free_reg != '0) begin
                    nf_next    = free_reg;
                    state_next = ST_NEWF;
                end else if ((FRAME_W+1)'(highest_reg) + 1'b1
                             < (FRAME_W+1)'(FRAME_COUNT)) begin
                    nf_next    = highest_reg + 1'b1;
                    state_next = ST_NEWF;
                end else begin
                    frame_req.raddr = vaddr_reg;
                    state_next      = ST_EVRD;
                end
            end
            ST_EVRD: begin
                nf_next    = frame_rdata[FRAME_W-1:0];
                k_next     = '0;
                rv_next    = 1'b0;
                state_next = ST_EVCP;
            end
            ST_EVCP: begin
                // Copy the victim page out to the swap store.
                if (rv_reg) begin
                    swap_req.we    = 1'b1;
                    swap_req.waddr = {vpage_reg, kd_reg};
                    swap_req.wdata = frame_rdata;
                end
                if (k_reg != IDX_W'(PAGE_WORDS)) begin
                    frame_req.raddr = {nf_reg, k_reg[OFFSET_BITS-1:0]};
                    kd_next         = k_reg[OFFSET_BITS-1:0];
                    k_next          = k_reg + 1'b1;
                    rv_next         = 1'b1;
                end else begin
                    rv_next    = 1'b0;
                    state_next = ST_EVEND;
                end
            end
            ST_EVEND: begin
                saved_req.we    = 1'b1;
                saved_req.waddr = vpage_reg;
                saved_req.wdata = 1'b1;
                frame_req.we    = 1'b1;
                frame_req.waddr = vaddr_reg;
                state_next      = ST_NEWF;
            end
            ST_NEWF: begin
                k_next  = '0;
                rv_next = 1'b0;
                if (level_reg != LVL_W'(LEVELS - 1)) begin
                    state_next = ST_TCLR;
                end else begin
                    saved_req.raddr = want_page;
                    state_next      = ST_SVRD;
                end
            end
            ST_TCLR: begin
                // A new table frame starts out empty.
                frame_req.we    = 1'b1;
                frame_req.waddr = {nf_reg, k_reg[OFFSET_BITS-1:0]};
                k_next          = k_reg + 1'b1;
                if (k_reg[OFFSET_BITS-1:0] == {OFFSET_BITS{1'b1}}) begin
                    state_next = ST_LINK;
                end
            end
            ST_SVRD: begin
                state_next = saved_rdata ? ST_SVCP : ST_LINK;
            end
            ST_SVCP: begin
                // Bring the saved page back from the swap store.
                if (rv_reg) begin
                    frame_req.we    = 1'b1;
                    frame_req.waddr = {nf_reg, kd_reg};
                    frame_req.wdata = swap_rdata;
                end
                if (k_reg != IDX_W'(PAGE_WORDS)) begin
                    swap_req.raddr = {want_page, k_reg[OFFSET_BITS-1:0]};
                    kd_next        = k_reg[OFFSET_BITS-1:0];
                    k_next         = k_reg + 1'b1;
                    rv_next        = 1'b1;
                end else begin
                    rv_next         = 1'b0;
                    saved_req.we    = 1'b1;
                    saved_req.waddr = want_page;
                    state_next      = ST_LINK;
                end
            end
            ST_LINK: begin
                frame_req.we    = 1'b1;
                frame_req.waddr = ea_reg;
                frame_req.wdata = WORD_BITS'(nf_reg);
                parent_next     = nf_reg;
                last_next       = nf_reg;
                if (level_reg == LVL_W'(LEVELS - 1)) begin
                    state_next = ST_ACC;
                end else begin
                    level_next = level_reg + 1'b1;
                    state_next = ST_WALK;
                end
            end
            ST_ACC: begin
                okr_next = 1'b1;
                if (op_reg == OP_WRITE) begin
                    frame_req.we    = 1'b1;
                    frame_req.waddr = {parent_reg, va_reg[OFFSET_BITS-1:0]};
                    frame_req.wdata = WORD_BITS'(wdata_reg);
                    res_next        = '0;
                    state_next      = ST_FIN;
                end else begin
                    frame_req.raddr = {parent_reg, va_reg[OFFSET_BITS-1:0]};
                    state_next      = ST_ADAT;
                end
            end
            ST_ADAT: begin
                res_next   = 32'(frame_rdata);
                state_next = ST_FIN;
            end
            ST_FIN: begin
                if (!mvalid_reg || m_ready) begin
                    mvalid_next = 1'b1;
                    mdata_next  = res_reg;
                    mok_next    = okr_reg;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_CLR;
            clr_reg    <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            mvalid_reg <= mvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg      <= op_next;
        va_reg      <= va_next;
        wdata_reg   <= wdata_next;
        level_reg   <= level_next;
        parent_reg  <= parent_next;
        last_reg    <= last_next;
        ea_reg      <= ea_next;
        sf_reg      <= sf_next;
        si_reg      <= si_next;
        sd_reg      <= sd_next;
        k_reg       <= k_next;
        kd_reg      <= kd_next;
        rv_reg      <= rv_next;
        allz_reg    <= allz_next;
        highest_reg <= highest_next;
        free_reg    <= free_next;
        nf_reg      <= nf_next;
        vaddr_reg   <= vaddr_next;
        vdist_reg   <= vdist_next;
        vpage_reg   <= vpage_next;
        res_reg     <= res_next;
        okr_reg     <= okr_next;
        mdata_reg   <= mdata_next;
        mok_reg     <= mok_next;
    end

endmodule
`default_nettype wire

>>> rtl/radix_page_table_walker_with_eviction.sv
`default_nettype none
// Demand-paged word memory behind a radix page table. Each item reads or writes one word at
// a virtual word address; addresses at or above 2^16 return ok=0 at once. After reset the
// block runs a clearing pass over its frame RAM and saved-page flags before it takes the
// first item. A hit reads one table entry per level and then makes the access. A missing
// entry starts a depth-first scan of the tree in the frame RAM, then clears a new table
// frame, or copies an evicted page out and a saved page back through the swap store.
// All of this is bound by the single read port of the frame RAM.
module radix_page_table_walker_with_eviction
    import rpw_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic               s_op,
    input  wire logic [31:0]        s_virtual_address,
    input  wire logic signed [31:0] s_write_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [31:0]      m_read_data,
    output logic                    m_ok
);

    frame_req_t           frame_req;
    swap_req_t            swap_req;
    saved_req_t           saved_req;
    logic [WORD_BITS-1:0] frame_rdata;
    logic [WORD_BITS-1:0] swap_rdata;
    logic                 saved_rdata;

    // Walk, scan and copy sequencer.
    rpw_ctrl u_ctrl (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_op              (s_op),
        .s_virtual_address (s_virtual_address),
        .s_write_data      (s_write_data),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_read_data       (m_read_data),
        .m_ok              (m_ok),
        .frame_req         (frame_req),
        .frame_rdata       (frame_rdata),
        .swap_req          (swap_req),
        .swap_rdata        (swap_rdata),
        .saved_req         (saved_req),
        .saved_rdata       (saved_rdata)
    );

    // Frame RAM holding the tables and the resident pages.
    rpw_ram #(.WIDTH(WORD_BITS), .DEPTH(RAM_DEPTH)) u_frame_ram (
        .aclk  (aclk),
        .we    (frame_req.we),
        .waddr (frame_req.waddr),
        .wdata (frame_req.wdata),
        .raddr (frame_req.raddr),
        .rdata (frame_rdata)
    );

    // Swap store for evicted pages.
    rpw_ram #(.WIDTH(WORD_BITS), .DEPTH(SWAP_DEPTH)) u_swap_ram (
        .aclk  (aclk),
        .we    (swap_req.we),
        .waddr (swap_req.waddr),
        .wdata (swap_req.wdata),
        .raddr (swap_req.raddr),
        .rdata (swap_rdata)
    );

    // One flag per page telling whether the swap store holds its copy.
    rpw_ram #(.WIDTH(1), .DEPTH(PAGE_COUNT)) u_saved_ram (
        .aclk  (aclk),
        .we    (saved_req.we),
        .waddr (saved_req.waddr),
        .wdata (saved_req.wdata),
        .raddr (saved_req.raddr),
        .rdata (saved_rdata)
    );

endmodule
`default_nettype wire
